[design/lsfb_pkg.sv]
// Shared constants, types and helpers for the self-tuning balancing controller.
`timescale 1ns / 1ps
`default_nettype none
package lsfb_pkg;

    localparam int GainCountDefault = 5;
    localparam int GainCountMax = 5;
    localparam int IdxW = 3;
    localparam int CostW = 47;
    localparam logic [CostW-1:0] CostMax = {CostW{1'b1}};

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_LOAD   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_TIME_STEP   = 3'd0,
        REG_SMOOTHING   = 3'd1,
        REG_LEARN_RATE  = 3'd2,
        REG_CHANGE_LIM  = 3'd3,
        REG_BASE_START  = 3'd4,
        REG_ALT_MODE    = 3'd5,
        REG_POS_LEARN   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [15:0]      time_step;
        logic [15:0]      smoothing;
        logic [23:0]      learning_rate;
        logic [30:0]      change_limit;
        logic             alternating;
        logic             pos_learning;
    } lsfb_cfg_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [CostW-1:0] satcost(input logic [63:0] v);
        logic [CostW-1:0] r;
        if (v > {17'd0, CostMax})
            r = CostMax;
        else
            r = v[CostW-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

[design/lsfb_mul.sv]
// Shared signed 33x33 multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module lsfb_mul
    import lsfb_pkg::*;
(
    input  wire logic                clk,
    input  wire logic signed [32:0]  a,
    input  wire logic signed [32:0]  b,
    output logic signed [65:0]       p
);
    logic signed [65:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;
endmodule
`default_nettype wire

[design/lsfb_core.sv]
// Sequencer that runs sample and update items through the shared multiplier; load items write a gain directly.
`timescale 1ns / 1ps
`default_nettype none
module lsfb_core
    import lsfb_pkg::*;
#(
    parameter int GAIN_COUNT = GainCountDefault
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lsfb_cfg_t         cfg,
    input  wire logic              base_load,
    input  wire logic [CostW-1:0]  base_value,
    input  wire logic              phase_set,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        cmd,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] angle,
    input  wire logic signed [31:0] pos_rate,
    input  wire logic signed [31:0] angle_rate,
    input  wire logic [GainCountMax*32-1:0] noise,
    input  wire logic [IdxW-1:0]   load_index,
    input  wire logic signed [31:0] load_value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic signed [31:0]     drive,
    output logic [CostW-1:0]       episode_cost
);
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL   = 7'b0000010,
        ST_ACC   = 7'b0000100,
        ST_COST  = 7'b0001000,
        ST_DTMUL = 7'b0010000,
        ST_UPD   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic signed [31:0] gains_reg [GainCountMax];
    logic signed [31:0] pert_reg [GainCountMax];
    logic signed [31:0] noise_reg [GainCountMax];
    logic [CostW-1:0]   cost_sum_reg;
    logic [CostW-1:0]   baseline_reg;
    logic               phase_reg;
    logic [1:0]         cmd_reg;
    logic signed [31:0] x_reg [4];
    logic [4:0]         step_reg;
    logic signed [63:0] acc_reg;
    logic [63:0]        cost_reg;
    logic signed [31:0] u_reg;
    logic signed [31:0] etastep_reg;
    logic [CostW-1:0]   finished_reg;
    logic [63:0]        newbase_reg;
    logic               out_valid_reg;
    logic signed [31:0] drive_reg;
    logic [CostW-1:0]   ecost_reg;

    logic signed [32:0] ma, mb;
    logic signed [65:0] mp;

    lsfb_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

    // Product pipeline: operands set in one step, product valid in the next.
    // Step map for samples: 0..3 gain products, 5 drive sq, 6..9 input sq, 10 dt.
    // Update: 0 eta*change, 2..6 step*p_i; the smoothing mix is formed without the multiplier.
    logic signed [31:0] ye;
    logic signed [63:0] ye_w;
    logic signed [47:0] chg_raw;
    logic signed [47:0] chg;
    logic signed [47:0] lim;
    logic [2:0]         gi;
    logic               alt_base;

    always_comb
    begin
        ye_w = (cfg.pos_learning && GAIN_COUNT >= 5)
            ? 64'(x_reg[0]) - 64'(gains_reg[GainCountMax-1]) : 64'(x_reg[0]);
        ye = sat32(ye_w);
        chg_raw = $signed({1'b0, cost_sum_reg}) - $signed({1'b0, baseline_reg});
        lim = 48'(cfg.change_limit);
        if (chg_raw > lim)
            chg = lim;
        else if (chg_raw < -lim)
            chg = -lim;
        else
            chg = chg_raw;
        gi = step_reg[2:0] - 3'd2;
        alt_base = cfg.alternating && phase_reg;
    end

    // Operand select for the shared multiplier.
    always_comb
    begin
        ma = '0;
        mb = '0;
        if (cmd_reg == CMD_SAMPLE)
        begin
            unique case (step_reg)
                5'd0: begin ma = 33'(gains_reg[0]); mb = 33'(ye); end
                5'd1: begin ma = 33'(gains_reg[1]); mb = 33'(x_reg[1]); end
                5'd2: begin ma = 33'(gains_reg[2]); mb = 33'(x_reg[2]); end
                5'd3: begin ma = 33'(gains_reg[3]); mb = 33'(x_reg[3]); end
                5'd5: begin ma = 33'(u_reg); mb = 33'(u_reg); end
                5'd6: begin ma = 33'(ye); mb = 33'(ye); end
                5'd7: begin ma = 33'(x_reg[1]); mb = 33'(x_reg[1]); end
                5'd8: begin ma = 33'(x_reg[2]); mb = 33'(x_reg[2]); end
                5'd9: begin ma = 33'(x_reg[3]); mb = 33'(x_reg[3]); end
                5'd10: begin ma = $signed({17'd0, cfg.time_step}); mb = 33'(0); end
                default: begin ma = '0; mb = '0; end
            endcase
        end
        else
        begin
            unique case (step_reg)
                5'd0: begin ma = $signed({9'd0, cfg.learning_rate}); mb = 33'(chg); end
                5'd2, 5'd3, 5'd4, 5'd5, 5'd6:
                begin
                    ma = 33'(etastep_reg);
                    mb = 33'(pert_reg[gi]);
                end
                default: begin ma = '0; mb = '0; end
            endcase
        end
    end

    // Squares are signed products of equal operands, which are nonnegative.
    logic [63:0] sq;
    logic [63:0] dt_prod;
    logic signed [63:0] prod_sh;
    logic [63:0]        cost_c;
    logic [63:0]        base_mix;

    always_comb
    begin
        sq = 64'(mp) >> 16;
        prod_sh = 64'(mp >>> 16);
        cost_c = (cost_reg > {17'd0, CostMax}) ? {17'd0, CostMax} : cost_reg;
        dt_prod = (64'(cfg.time_step) * cost_c) >> 16;
        base_mix = (64'(cost_sum_reg) * 64'(17'h10000 - 17'(cfg.smoothing))
            + 64'(cfg.smoothing) * 64'(baseline_reg)) >> 16;
    end

    assign in_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign drive = drive_reg;
    assign episode_cost = ecost_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid && in_ready)
                begin
                    if (cmd == CMD_SAMPLE)
                        state_next = ST_MUL;
                    else if (cmd == CMD_UPDATE)
                        state_next = ST_UPD;
                end
            ST_MUL:   state_next = (step_reg == 5'd4) ? ST_ACC : ST_MUL;
            ST_ACC:   state_next = ST_COST;
            ST_COST:  state_next = (step_reg == 5'd10) ? ST_DTMUL : ST_COST;
            ST_DTMUL: state_next = ST_OUT;
            ST_UPD:   state_next = (step_reg == 5'd7) ? ST_OUT : ST_UPD;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cost_sum_reg <= '0;
            baseline_reg <= CostW'(327680);
            phase_reg <= 1'b1;
            step_reg <= '0;
            cmd_reg <= CMD_SAMPLE;
            for (int i = 0; i < GainCountMax; i++)
            begin
                gains_reg[i] <= '0;
                pert_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (base_load)
                baseline_reg <= base_value;
            if (phase_set)
                phase_reg <= 1'b1;
            unique case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (in_valid && in_ready)
                    begin
                        cmd_reg <= cmd;
                        x_reg[0] <= pos_y;
                        x_reg[1] <= angle;
                        x_reg[2] <= pos_rate;
                        x_reg[3] <= angle_rate;
                        for (int i = 0; i < GainCountMax; i++)
                            noise_reg[i] <= noise[i*32 +: 32];
                        acc_reg <= '0;
                        cost_reg <= '0;
                        finished_reg <= cost_sum_reg;
                        if (cmd == CMD_LOAD && 32'(load_index) < GAIN_COUNT)
                            gains_reg[load_index] <= load_value;
                    end
                end
                ST_MUL:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg != 5'd0)
                        acc_reg <= acc_reg + prod_sh;
                end
                ST_ACC:
                begin
                    u_reg <= sat32(-acc_reg);
                    step_reg <= 5'd5;
                end
                ST_COST:
                begin
                    step_reg <= step_reg + 5'd1;
                    unique case (step_reg)
                        5'd6: cost_reg <= cost_reg + 64'd10 * sq;
                        5'd7: cost_reg <= cost_reg + 64'd20 * sq;
                        5'd8: cost_reg <= cost_reg + 64'd5 * sq;
                        5'd9: cost_reg <= cost_reg + 64'd2 * sq;
                        5'd10: cost_reg <= cost_reg + (sq >> 1);
                        default: cost_reg <= cost_reg;
                    endcase
                end
                ST_DTMUL:
                begin
                    cost_sum_reg <= satcost(64'(cost_sum_reg) + dt_prod);
                    drive_reg <= u_reg;
                    ecost_reg <= '0;
                end
                ST_UPD:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd1)
                    begin
                        etastep_reg <= sat32(prod_sh);
                        newbase_reg <= base_mix;
                    end
                    if (step_reg >= 5'd3 && 32'(gi) - 1 < GAIN_COUNT && !alt_base)
                    begin
                        if (cfg.alternating)
                            gains_reg[gi - 3'd1] <= sat32(64'(gains_reg[gi - 3'd1])
                                - prod_sh - 64'(pert_reg[gi - 3'd1]));
                        else
                            gains_reg[gi - 3'd1] <= sat32(64'(gains_reg[gi - 3'd1])
                                - prod_sh);
                    end
                end
                ST_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    if (cmd_reg == CMD_UPDATE)
                    begin
                        drive_reg <= '0;
                        ecost_reg <= finished_reg;
                        cost_sum_reg <= '0;
                        if (alt_base)
                        begin
                            phase_reg <= 1'b0;
                            baseline_reg <= cost_sum_reg;
                        end
                        else if (cfg.alternating)
                            phase_reg <= 1'b1;
                        else
                            baseline_reg <= satcost(newbase_reg);
                        if (!cfg.alternating || phase_reg)
                        begin
                            for (int i = 0; i < GainCountMax; i++)
                            begin
                                if (i < GAIN_COUNT)
                                begin
                                    pert_reg[i] <= noise_reg[i];
                                    gains_reg[i] <= sat32(64'(gains_reg[i])
                                        + 64'(noise_reg[i]));
                                end
                            end
                        end
                    end
                end
                default: step_reg <= '0;
            endcase
        end
    end
endmodule
`default_nettype wire

[design/learning_state_feedback_balancer_top.sv]
// Top level of the self-tuning balancing controller: stream ports and registers.
// A sample beat runs MUL, ACC, COST, DTMUL and OUT to its result; an update beat runs UPD and OUT.
// A load beat gives no result.
// One beat is worked at a time through the shared multiplier.
// The next beat is taken once the previous result has been taken.
// Reset is asynchronous and active low; it restores gains and registers to defaults.
`timescale 1ns / 1ps
`default_nettype none
module learning_state_feedback_balancer_top
    import lsfb_pkg::*;
#(
    parameter int GAIN_COUNT = GainCountDefault
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [46:0]   cfg_data,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // cmd[1:0], pos_y, angle, pos_rate, angle_rate, noise_0..noise_4,
    // load_index[2:0], load_value; zero fill to 328 bits
    input  wire logic [327:0]  s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // drive[31:0], episode_cost[78:32]; zero fill to 80 bits
    output logic [79:0]        m_tdata
);
    lsfb_cfg_t cfg_reg;
    logic signed [31:0] drive;
    logic [CostW-1:0]   episode_cost;
    logic base_load, phase_set;

    assign base_load = cfg_we && cfg_index == REG_BASE_START;
    assign phase_set = cfg_we && cfg_index == REG_ALT_MODE && cfg_data[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_step <= 16'd655;
            cfg_reg.smoothing <= 16'd62259;
            cfg_reg.learning_rate <= 24'd131072;
            cfg_reg.change_limit <= 31'd32768;
            cfg_reg.alternating <= 1'b0;
            cfg_reg.pos_learning <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIME_STEP:  cfg_reg.time_step <= cfg_data[15:0];
                REG_SMOOTHING:  cfg_reg.smoothing <= cfg_data[15:0];
                REG_LEARN_RATE: cfg_reg.learning_rate <= cfg_data[23:0];
                REG_CHANGE_LIM: cfg_reg.change_limit <= cfg_data[30:0];
                REG_ALT_MODE:   cfg_reg.alternating <= cfg_data[0];
                REG_POS_LEARN:  cfg_reg.pos_learning <= cfg_data[0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    lsfb_core #(.GAIN_COUNT(GAIN_COUNT)) u_core (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .base_load(base_load), .base_value(cfg_data),
        .phase_set(phase_set),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .cmd(s_tdata[1:0]),
        .pos_y(s_tdata[33:2]), .angle(s_tdata[65:34]),
        .pos_rate(s_tdata[97:66]), .angle_rate(s_tdata[129:98]),
        .noise(s_tdata[289:130]),
        .load_index(s_tdata[292:290]), .load_value(s_tdata[324:293]),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .drive(drive), .episode_cost(episode_cost)
    );

    assign m_tdata = {1'b0, episode_cost, drive};
endmodule
`default_nettype wire

[design/lsfb_checker.sv]
// Port checker for the balancing controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lsfb_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped while stalled");
    a_noin: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while result waits");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !m_tvalid)
        else $error("result right after accept");
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[31:0] != 32'd0) |-> m_tdata[78:32] == 47'd0)
        else $error("both fields nonzero");
endmodule

bind learning_state_feedback_balancer_top lsfb_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
